// ===== rtl/glcm_ad_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and widths for the co-occurrence accumulator
package glcm_ad_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W     = 22;
    localparam int unsigned VALUE_W   = 29;

    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = CFG_W'(1024);

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_SUM   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE  = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_PAIR,
        ST_INC_A,
        ST_INC_B,
        ST_ENTRY_RD,
        ST_SUM_RUN,
        ST_SUM_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic ld_item;
        logic clr_pos;
        logic sweep_rst;
        logic sweep_step;
        logic clear_wr;
        logic pix_step;
        logic pair_rd;
        logic inc_a;
        logic inc_b;
        logic entry_rd;
        logic sum_issue;
        logic sum_clr;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic frame_done;
        logic pair_en;
        logic sweep_last;
        logic sum_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/glcm_ad_in_if.sv =====
`timescale 1ns / 1ps
// input item channel: operation, pixel and entry coordinates
interface glcm_ad_in_if;
    import glcm_ad_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [PIX_W-1:0] pixel;
    logic [PIX_W-1:0] entry_row;
    logic [PIX_W-1:0] entry_col;

    modport source (output valid, output operation, output pixel, output entry_row,
                    output entry_col, input ready);
    modport sink (input valid, input operation, input pixel, input entry_row,
                  input entry_col, output ready);
endinterface

// ===== rtl/glcm_ad_out_if.sv =====
`timescale 1ns / 1ps
// result item channel: entry count or dissimilarity sum
interface glcm_ad_out_if;
    import glcm_ad_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               is_sum;

    modport source (output valid, output value, output is_sum, input ready);
    modport sink (input valid, input value, input is_sum, output ready);
endinterface

// ===== rtl/glcm_accumulate_dissimilarity_unit.sv =====
`timescale 1ns / 1ps
// pixel item: position step, pair check, then two increments when a pair is counted; none past frame end
// read item: entry read, then the result is loaded into the output register once it is free
// sum item: walks all GRAY_LEVELS^2 entries, one count memory read per cycle, then drains the pipeline
// clear item: walks all GRAY_LEVELS^2 entries, one count memory entry written per cycle
// synchronous reset runs a clearing pass over all GRAY_LEVELS^2 entries before the first item
// is taken; pair counts per pixel are bound by the single write port of the count memory
module glcm_accumulate_dissimilarity_unit #(
    parameter int unsigned GRAY_LEVELS = 256,
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_HEIGHT  = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    glcm_ad_in_if.sink                         i_in,
    glcm_ad_out_if.source                      o_out,
    input  logic                               i_cfg_we,
    input  logic [glcm_ad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [glcm_ad_pkg::CFG_W-1:0]      i_cfg_data
);
    import glcm_ad_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_in.ready = in_ready;

    glcm_ad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (t_op'(i_in.operation)),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    glcm_ad_dp #(
        .GRAY_LEVELS (GRAY_LEVELS),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_operation (i_in.operation),
        .i_pixel     (i_in.pixel),
        .i_entry_row (i_in.entry_row),
        .i_entry_col (i_in.entry_col),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out.valid),
        .o_value     (o_out.value),
        .o_is_sum    (o_out.is_sum),
        .i_out_ready (o_out.ready)
    );

endmodule

// ===== rtl/glcm_ad_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine sequencing pixel, read, sum and clear items
module glcm_ad_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  glcm_ad_pkg::t_op    i_in_op,
    output logic                o_in_ready,
    input  glcm_ad_pkg::t_stat  i_stat,
    output glcm_ad_pkg::t_cmd   o_cmd
);
    import glcm_ad_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr   = 1'b1;
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    unique case (i_in_op)
                        OP_PIXEL: begin
                            n_state = ST_PIX_RD;
                        end
                        OP_READ: begin
                            n_state = ST_ENTRY_RD;
                        end
                        OP_SUM: begin
                            o_cmd.sweep_rst = 1'b1;
                            o_cmd.sum_clr   = 1'b1;
                            n_state         = ST_SUM_RUN;
                        end
                        OP_CLEAR: begin
                            o_cmd.clr_pos   = 1'b1;
                            o_cmd.sweep_rst = 1'b1;
                            n_state         = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_PIX_RD: begin
                // a pixel past the end of the frame is dropped untouched
                if (i_stat.frame_done) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.pix_step = 1'b1;
                    n_state        = ST_PIX_PAIR;
                end
            end
            ST_PIX_PAIR: begin
                if (i_stat.pair_en) begin
                    o_cmd.pair_rd = 1'b1;
                    n_state       = ST_INC_A;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_INC_A: begin
                o_cmd.inc_a = 1'b1;
                n_state     = ST_INC_B;
            end
            ST_INC_B: begin
                o_cmd.inc_b = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_ENTRY_RD: begin
                o_cmd.entry_rd = 1'b1;
                n_state        = ST_RESULT;
            end
            ST_SUM_RUN: begin
                o_cmd.sum_issue  = 1'b1;
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_SUM_DRAIN;
                end
            end
            ST_SUM_DRAIN: begin
                if (!i_stat.sum_busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_clear_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_in_op == OP_CLEAR) |=> r_state == ST_CLEAR)
        else $error("clear item did not start the matrix walk");

    a_inc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INC_B) |-> $past(r_state) == ST_INC_A)
        else $error("second increment without the first");

    a_result_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && i_stat.out_free) |=> r_state == ST_IDLE)
        else $error("result not handed to the output register");

endmodule

// ===== rtl/glcm_ad_dp.sv =====
`timescale 1ns / 1ps
// datapath: count memory, line store, positions, sum pipeline, output register
module glcm_ad_dp #(
    parameter int unsigned GRAY_LEVELS = 256,
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_HEIGHT  = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  glcm_ad_pkg::t_cmd                    i_cmd,
    output glcm_ad_pkg::t_stat                   o_stat,
    input  logic [glcm_ad_pkg::OP_W-1:0]         i_operation,
    input  logic [glcm_ad_pkg::PIX_W-1:0]        i_pixel,
    input  logic [glcm_ad_pkg::PIX_W-1:0]        i_entry_row,
    input  logic [glcm_ad_pkg::PIX_W-1:0]        i_entry_col,
    input  logic                                 i_cfg_we,
    input  logic [glcm_ad_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [glcm_ad_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                                 o_out_valid,
    output logic [glcm_ad_pkg::VALUE_W-1:0]      o_value,
    output logic                                 o_is_sum,
    input  logic                                 i_out_ready
);
    import glcm_ad_pkg::*;

    localparam int unsigned LW    = $clog2(GRAY_LEVELS);
    localparam int unsigned DEPTH = GRAY_LEVELS * GRAY_LEVELS;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned XW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ?
                                    $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int unsigned XH    = ($clog2(MAX_HEIGHT + 1) > CFG_W) ?
                                    $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int unsigned PW    = LW + CNT_W;
    localparam int unsigned SUM_W = ((PW > VALUE_W) ? PW : VALUE_W) + 1;
    localparam int unsigned GW    = PIX_W + 1;

    localparam logic [LW-1:0] LVL_TOP = LW'(GRAY_LEVELS - 1);

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] a,
                                              input logic [LW-1:0] b);
        return AW'(32'(a) * GRAY_LEVELS + 32'(b));
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? x : x + CNT_W'(1);
    endfunction

    // configuration
    logic             r_mode;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_width  <= CFG_SIZE_RESET;
            r_height <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ANGLE:  r_mode   <= i_cfg_data[0];
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // zero is used as one, oversize as the maximum
    logic [XW-1:0] frame_w;
    logic [XH-1:0] frame_h;

    assign frame_w = (r_width == '0) ? XW'(1) :
                     (XW'(r_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(r_width);
    assign frame_h = (r_height == '0) ? XH'(1) :
                     (XH'(r_height) > XH'(MAX_HEIGHT)) ? XH'(MAX_HEIGHT) : XH'(r_height);

    // item latch
    t_op           r_op;
    logic [LW-1:0] r_px;
    logic [LW-1:0] r_er;
    logic [LW-1:0] r_ec;
    logic          r_entry_ok;
    logic [LW-1:0] in_lvl;

    assign in_lvl = (GW'(i_pixel) >= GW'(GRAY_LEVELS)) ? LVL_TOP : LW'(i_pixel);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op       <= t_op'(i_operation);
            r_px       <= in_lvl;
            r_er       <= LW'(i_entry_row);
            r_ec       <= LW'(i_entry_col);
            r_entry_ok <= (GW'(i_entry_row) < GW'(GRAY_LEVELS)) &&
                          (GW'(i_entry_col) < GW'(GRAY_LEVELS));
        end
    end

    // raster position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          end_row;

    assign end_row = (XW'(r_col) + XW'(1)) >= frame_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.clr_pos) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.pix_step) begin
            if (end_row) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // line store and neighbor selection
    logic [LW-1:0] r_line [MAX_WIDTH];
    logic [LW-1:0] r_ls_rd;
    logic [LW-1:0] r_prev;
    logic [LW-1:0] r_a_prev;
    logic          r_use_up;
    logic          r_pair_en;
    logic [LW-1:0] r_a;
    logic [LW-1:0] pair_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_step) begin
            r_line[r_col] <= r_px;
            r_ls_rd       <= r_line[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_cmd.pix_step) begin
            r_prev <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_step) begin
            r_a_prev  <= r_prev;
            r_use_up  <= r_mode;
            r_pair_en <= r_mode ? (r_row != '0) : (r_col != '0);
        end
        if (i_cmd.pair_rd) begin
            r_a <= pair_a;
        end
    end

    assign pair_a = r_use_up ? r_ls_rd : r_a_prev;

    // walk counters shared by clear and sum
    logic [LW-1:0] r_si;
    logic [LW-1:0] r_sj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si <= '0;
            r_sj <= '0;
        end else if (i_cmd.sweep_rst) begin
            r_si <= '0;
            r_sj <= '0;
        end else if (i_cmd.sweep_step) begin
            if (r_sj == LVL_TOP) begin
                r_sj <= '0;
                r_si <= r_si + LW'(1);
            end else begin
                r_sj <= r_sj + LW'(1);
            end
        end
    end

    // count memory, one write and one read port
    logic [CNT_W-1:0] r_cnt_mem [DEPTH];
    logic [CNT_W-1:0] r_cnt_rd;
    logic             cnt_re;
    logic [AW-1:0]    cnt_raddr;
    logic             cnt_we;
    logic [AW-1:0]    cnt_waddr;
    logic [CNT_W-1:0] cnt_wdata;
    logic             r_fwd;
    logic [CNT_W-1:0] r_wlast;

    always_comb begin
        cnt_re    = 1'b0;
        cnt_raddr = '0;
        if (i_cmd.pair_rd) begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_of(pair_a, r_px);
        end else if (i_cmd.inc_a) begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_of(r_px, r_a);
        end else if (i_cmd.entry_rd) begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_of(r_er, r_ec);
        end else if (i_cmd.sum_issue) begin
            cnt_re    = 1'b1;
            cnt_raddr = addr_of(r_si, r_sj);
        end
    end

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = '0;
        cnt_wdata = '0;
        if (i_cmd.clear_wr) begin
            cnt_we    = 1'b1;
            cnt_waddr = addr_of(r_si, r_sj);
        end else if (i_cmd.inc_a) begin
            cnt_we    = 1'b1;
            cnt_waddr = addr_of(r_a, r_px);
            cnt_wdata = sat_inc(r_cnt_rd);
        end else if (i_cmd.inc_b) begin
            // an equal pair hits the entry just written: take that value
            cnt_we    = 1'b1;
            cnt_waddr = addr_of(r_px, r_a);
            cnt_wdata = sat_inc(r_fwd ? r_wlast : r_cnt_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= r_cnt_mem[cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.inc_a) begin
            r_fwd   <= (r_a == r_px);
            r_wlast <= sat_inc(r_cnt_rd);
        end
    end

    // dissimilarity pipeline: read, weight, saturating accumulate
    logic               r_s1_v;
    logic               r_s2_v;
    logic [LW-1:0]      r_s1_d;
    logic [PW-1:0]      r_prod;
    logic [VALUE_W-1:0] r_acc;
    logic [LW-1:0]      lvl_diff;
    logic [SUM_W-1:0]   acc_sum;

    assign lvl_diff = (r_si > r_sj) ? (r_si - r_sj) : (r_sj - r_si);
    assign acc_sum  = SUM_W'(r_acc) + SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.sum_issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_issue) begin
            r_s1_d <= lvl_diff;
        end
        r_prod <= PW'(r_s1_d) * PW'(r_cnt_rd);
        if (i_cmd.sum_clr) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= (acc_sum > SUM_W'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(acc_sum);
        end
    end

    // output register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_is_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_is_sum <= (r_op == OP_SUM);
            if (r_op == OP_SUM) begin
                r_out_value <= r_acc;
            end else begin
                r_out_value <= r_entry_ok ? VALUE_W'(r_cnt_rd) : '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_is_sum    = r_out_is_sum;

    assign o_stat.frame_done = XH'(r_row) >= frame_h;
    assign o_stat.pair_en    = r_pair_en;
    assign o_stat.sweep_last = (r_si == LVL_TOP) && (r_sj == LVL_TOP);
    assign o_stat.sum_busy   = r_s1_v || r_s2_v;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear_wr, i_cmd.inc_a, i_cmd.inc_b}))
        else $error("two writers on the count memory");

    a_sum_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_op == OP_SUM) |-> (!r_s1_v && !r_s2_v))
        else $error("sum loaded before the pipeline drained");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= RW'(MAX_HEIGHT))
        else $error("row position past the largest frame");

endmodule
